// ===== rtl/peer_keepalive_aging_table_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the peer keepalive aging table
// Concurrent checks clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PEER_KEEPALIVE_AGING_TABLE_ASSERT_SVH
`define PEER_KEEPALIVE_AGING_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PKAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define PKAT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PKAT_ASSERT(lbl, prop, msg)

`define PKAT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/pkat_pkg.sv =====
// ---------------------------------------------------------------------------
// Peer keepalive aging table package
// Table size, entry layout, event codes, register indexes and sequencer
// states.
// ---------------------------------------------------------------------------
`default_nettype none

package pkat_pkg;

  localparam int PEER_SLOTS = 16;
  localparam int SLOT_W     = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int CNT_W      = $clog2(PEER_SLOTS + 1);

  localparam logic [15:0] ODD_MASK = 16'h0001;

  localparam logic [1:0] EV_UNICAST   = 2'd0;
  localparam logic [1:0] EV_OFFLINE   = 2'd1;
  localparam logic [1:0] EV_BROADCAST = 2'd2;
  localparam logic [1:0] EV_DONE      = 2'd3;

  localparam logic [1:0] CFG_PERIOD    = 2'd0;
  localparam logic [1:0] CFG_MAX_KA    = 2'd1;
  localparam logic [1:0] CFG_BC_ENABLE = 2'd2;
  localparam logic [1:0] CFG_BC_PORT   = 2'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  seed;
    logic [15:0] idle;
    logic [7:0]  probe;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_BCAST,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/peer_keepalive_aging_table.sv =====
// ---------------------------------------------------------------------------
// Peer keepalive aging table
// Holds the peer slots in one synchronous memory. A tick walks the slots,
// ages them, emits keepalive and offline words, then a broadcast when due and a done word.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake               Content
// in_       slave      in_tvalid / in_tready   opcode, slot, peer, seed
// out_      master     out_tvalid / out_tready event kind, slot, ip, port
// cfg_      write      cfg_we                  four configuration registers
//
// A write item yields one done word.
// A tick reads the memory read port once per slot while the previous
// slot is written back.
// Reset clears the valid bits of all slots at once; there is no clearing pass.
// A stalled output word holds the walk at the slot that wants to emit.
// ---------------------------------------------------------------------------
`default_nettype none

module peer_keepalive_aging_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // slot, peer_ip, peer_port, jitter_seed, zero fill
  input  wire logic [0:0]  in_tuser,   // opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // event_slot, event_ip, event_port, zero fill
  output logic [1:0]       out_tuser,  // event_kind
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam int SW = pkat_pkg::SLOT_W;
  localparam int CW = pkat_pkg::CNT_W;

  logic [15:0] period_r;
  logic [7:0]  maxk_r;
  logic        bc_en_r;
  logic [15:0] bc_port_r;

  pkat_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [SW-1:0]    ev_idx_r, ev_idx_nxt;
  logic             ev_pend_r, ev_pend_nxt;
  logic [16:0]      bc_cnt_r, bc_cnt_nxt;

  pkat_pkg::entry_t mem [pkat_pkg::PEER_SLOTS];
  logic [pkat_pkg::PEER_SLOTS-1:0] vld_r;
  pkat_pkg::entry_t rd_data_r;
  logic             rd_vld_r;
  logic             rd_en;
  logic [SW-1:0]    rd_addr;
  logic             mem_we;
  logic [SW-1:0]    wr_addr;
  pkat_pkg::entry_t wr_data;

  logic        out_valid_r;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic [31:0] out_ip_r, out_ip_nxt;
  logic [15:0] out_port_r, out_port_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_load;
  logic        out_free;

  logic [3:0]  in_slot;
  logic [31:0] in_ip;
  logic [15:0] in_port;
  logic [7:0]  in_seed;

  pkat_pkg::entry_t cur, upd;
  logic        active, over, evict, probe_go, emit_slot;
  logic [15:0] idle_inc;
  logic [16:0] limit;

  assign in_slot = in_tdata[3:0];
  assign in_ip   = in_tdata[35:4];
  assign in_port = in_tdata[51:36];
  assign in_seed = in_tdata[59:52];

  assign rd_addr  = rd_idx_r[SW-1:0];
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= 16'd60;
      maxk_r    <= 8'd3;
      bc_en_r   <= 1'b1;
      bc_port_r <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        pkat_pkg::CFG_PERIOD:    period_r  <= cfg_wdata;
        pkat_pkg::CFG_MAX_KA:    maxk_r    <= cfg_wdata[7:0];
        pkat_pkg::CFG_BC_ENABLE: bc_en_r   <= cfg_wdata[0];
        pkat_pkg::CFG_BC_PORT:   bc_port_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    cur      = rd_vld_r ? rd_data_r : '0;
    active   = (cur.ip != 32'd0) && (cur.port != 16'd0);
    idle_inc = (&cur.idle) ? cur.idle : cur.idle + 16'd1;
    limit    = {1'b0, period_r} + {9'd0, cur.seed};
    over     = active && ({1'b0, idle_inc} > limit);
    evict    = over && (cur.probe > maxk_r);
    probe_go = over && !evict &&
               ((cur.probe == 8'd0) || ((idle_inc & pkat_pkg::ODD_MASK) != 16'd0));
    emit_slot = evict || probe_go;
    upd = cur;
    if (active) begin
      upd.idle = idle_inc;
    end
    if (probe_go && !(&cur.probe)) begin
      upd.probe = cur.probe + 8'd1;
    end
    if (evict) begin
      upd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pkat_pkg::ST_IDLE;
      rd_idx_r  <= '0;
      ev_idx_r  <= '0;
      ev_pend_r <= 1'b0;
      bc_cnt_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      ev_idx_r  <= ev_idx_nxt;
      ev_pend_r <= ev_pend_nxt;
      bc_cnt_r  <= bc_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    ev_idx_nxt   = ev_idx_r;
    ev_pend_nxt  = ev_pend_r;
    bc_cnt_nxt   = bc_cnt_r;
    in_tready    = 1'b0;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    wr_addr      = ev_idx_r;
    wr_data      = upd;
    out_load     = 1'b0;
    out_kind_nxt = pkat_pkg::EV_DONE;
    out_slot_nxt = 4'd0;
    out_ip_nxt   = 32'd0;
    out_port_nxt = 16'd0;
    out_last_nxt = 1'b0;
    case (state_r)
      pkat_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser[0] == pkat_pkg::OP_WRITE) begin
            if (32'(in_slot) < pkat_pkg::PEER_SLOTS) begin
              mem_we  = 1'b1;
              wr_addr = SW'(in_slot);
              wr_data = '{ip: in_ip, port: in_port, seed: in_seed,
                          idle: 16'd0, probe: 8'd0};
            end
            state_nxt = pkat_pkg::ST_DONE;
          end else begin
            rd_idx_nxt  = '0;
            ev_pend_nxt = 1'b0;
            state_nxt   = pkat_pkg::ST_WALK;
          end
        end
      end
      pkat_pkg::ST_WALK: begin
        if (!(ev_pend_r && emit_slot) || out_free) begin
          if (ev_pend_r) begin
            mem_we = 1'b1;
            if (emit_slot) begin
              out_load     = 1'b1;
              out_kind_nxt = evict ? pkat_pkg::EV_OFFLINE : pkat_pkg::EV_UNICAST;
              out_slot_nxt = 4'(ev_idx_r);
              out_ip_nxt   = cur.ip;
              out_port_nxt = cur.port;
            end
          end
          if (rd_idx_r < CW'(pkat_pkg::PEER_SLOTS)) begin
            rd_en       = 1'b1;
            ev_pend_nxt = 1'b1;
            ev_idx_nxt  = rd_addr;
            rd_idx_nxt  = rd_idx_r + 1'b1;
          end else begin
            ev_pend_nxt = 1'b0;
            state_nxt   = pkat_pkg::ST_BCAST;
          end
        end
      end
      pkat_pkg::ST_BCAST: begin
        if (bc_cnt_r == 17'd0) begin
          if (!bc_en_r) begin
            bc_cnt_nxt = {1'b0, period_r};
            state_nxt  = pkat_pkg::ST_DONE;
          end else if (out_free) begin
            out_load     = 1'b1;
            out_kind_nxt = pkat_pkg::EV_BROADCAST;
            out_ip_nxt   = 32'hFFFF_FFFF;
            out_port_nxt = bc_port_r;
            bc_cnt_nxt   = {1'b0, period_r};
            state_nxt    = pkat_pkg::ST_DONE;
          end
        end else begin
          bc_cnt_nxt = bc_cnt_r - 17'd1;
          state_nxt  = pkat_pkg::ST_DONE;
        end
      end
      pkat_pkg::ST_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = pkat_pkg::EV_DONE;
          out_last_nxt = 1'b1;
          state_nxt    = pkat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pkat_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_slot_r <= out_slot_nxt;
      out_ip_r   <= out_ip_nxt;
      out_port_r <= out_port_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_port_r, out_ip_r, out_slot_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`include "peer_keepalive_aging_table_assert.svh"

  `PKAT_ASSERT(a_last_is_done,
               out_tvalid && out_tlast |-> out_tuser == pkat_pkg::EV_DONE,
               "last word is not a done word")
  `PKAT_ASSERT(a_pend_in_walk,
               ev_pend_r |-> state_r == pkat_pkg::ST_WALK,
               "slot pending outside the walk")
  `PKAT_NEVER(a_no_rw_clash,
              mem_we && rd_en && wr_addr == rd_addr,
              "write-back and read hit the same slot")
  `PKAT_ASSERT(a_tick_starts_walk,
               in_tvalid && in_tready && in_tuser[0] == pkat_pkg::OP_TICK |=>
               state_r == pkat_pkg::ST_WALK && rd_idx_r == '0 && !ev_pend_r,
               "tick did not start the walk at slot zero")

endmodule

`default_nettype wire

// ===== tb/peer_keepalive_aging_table_tb.sv =====
// ---------------------------------------------------------------------------
// Peer keepalive aging table testbench
// Drives write and tick words into the table and checks every event word
// against a shadow copy of the table, its counters and its registers. The
// directed tasks cover broadcast timing, probing and eviction; a random task
// mixes writes and ticks under changing registers. Both channels idle at
// random, with some stretches left clear.
// ---------------------------------------------------------------------------
module peer_keepalive_aging_table_tb;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * pkat_pkg::PEER_SLOTS + 10;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] ip;
    logic [15:0] port;
    logic        last;
  } event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  logic [31:0] tbl_ip    [pkat_pkg::PEER_SLOTS];
  logic [15:0] tbl_port  [pkat_pkg::PEER_SLOTS];
  logic [7:0]  tbl_seed  [pkat_pkg::PEER_SLOTS];
  logic [15:0] tbl_idle  [pkat_pkg::PEER_SLOTS];
  logic [7:0]  tbl_probe [pkat_pkg::PEER_SLOTS];
  logic [16:0] bc_countdown;
  logic [15:0] period_reg;
  logic [7:0]  max_ka_reg;
  logic        bc_en_reg;
  logic [15:0] bc_port_reg;

  event_t due_events[$];
  int     fail_count = 0;
  int     idle_cycles = 0;
  int     stall_left = 0;
  bit     no_gaps = 1'b0;

  always #5 clk = ~clk;

  peer_keepalive_aging_table DUT (.*);

  function automatic void clear_slot(int s);
    tbl_ip[s]    = '0;
    tbl_port[s]  = '0;
    tbl_seed[s]  = '0;
    tbl_idle[s]  = '0;
    tbl_probe[s] = '0;
  endfunction

  function automatic void reset_shadow();
    for (int s = 0; s < pkat_pkg::PEER_SLOTS; s++) clear_slot(s);
    bc_countdown = '0;
    period_reg   = 16'd60;
    max_ka_reg   = 8'd3;
    bc_en_reg    = 1'b1;
    bc_port_reg  = 16'd0;
  endfunction

  function automatic void push_event(logic [1:0] kind, logic [3:0] slot, logic [31:0] ip,
                                     logic [15:0] port, logic last);
    event_t e;
    e.kind = kind;
    e.slot = slot;
    e.ip   = ip;
    e.port = port;
    e.last = last;
    due_events.push_back(e);
  endfunction

  // Writes a slot or ages the shadow table; queues the event words it causes.
  function automatic void compute_events(logic op, logic [3:0] slot, logic [31:0] ip,
                                         logic [15:0] port, logic [7:0] seed);
    int limit;
    if (op == pkat_pkg::OP_WRITE) begin
      if (slot < pkat_pkg::PEER_SLOTS) begin
        tbl_ip[slot]    = ip;
        tbl_port[slot]  = port;
        tbl_seed[slot]  = seed;
        tbl_idle[slot]  = '0;
        tbl_probe[slot] = '0;
      end
      push_event(pkat_pkg::EV_DONE, 4'd0, 32'd0, 16'd0, 1'b1);
      return;
    end
    for (int s = 0; s < pkat_pkg::PEER_SLOTS; s++) begin
      if (tbl_ip[s] != 0 && tbl_port[s] != 0) begin
        if (tbl_idle[s] != 16'hFFFF) tbl_idle[s]++;
        limit = int'(period_reg) + int'(tbl_seed[s]);
        if (int'(tbl_idle[s]) > limit) begin
          if (tbl_probe[s] > max_ka_reg) begin
            push_event(pkat_pkg::EV_OFFLINE, 4'(s), tbl_ip[s], tbl_port[s], 1'b0);
            clear_slot(s);
          end else if (tbl_probe[s] == 0 ||
                       (tbl_idle[s] & pkat_pkg::ODD_MASK) != 0) begin
            if (tbl_probe[s] != 8'hFF) tbl_probe[s]++;
            push_event(pkat_pkg::EV_UNICAST, 4'(s), tbl_ip[s], tbl_port[s], 1'b0);
          end
        end
      end
    end
    if (bc_countdown == 0) begin
      if (bc_en_reg)
        push_event(pkat_pkg::EV_BROADCAST, 4'd0, 32'hFFFF_FFFF, bc_port_reg, 1'b0);
      bc_countdown = {1'b0, period_reg};
    end else begin
      bc_countdown = bc_countdown - 17'd1;
    end
    push_event(pkat_pkg::EV_DONE, 4'd0, 32'd0, 16'd0, 1'b1);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pkat_pkg::CFG_PERIOD:    period_reg = val;
      pkat_pkg::CFG_MAX_KA:    max_ka_reg = val[7:0];
      pkat_pkg::CFG_BC_ENABLE: bc_en_reg = val[0];
      default:                 bc_port_reg = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(logic op, logic [3:0] slot, logic [31:0] ip, logic [15:0] port,
                           logic [7:0] seed);
    int gap;
    gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, seed, port, ip, slot};
    do @(posedge clk); while (!in_tready);
    compute_events(op, slot, ip, port, seed);
  endtask

  task automatic send_tick();
    send_item(pkat_pkg::OP_TICK, 4'($urandom_range(0, 15)), $urandom(), 16'($urandom()),
              8'($urandom()));
  endtask

  // Holds the input back until every queued event word has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_broadcast();
    write_reg(pkat_pkg::CFG_PERIOD, 16'd2);
    repeat (4) send_tick();
    drain();
    write_reg(pkat_pkg::CFG_BC_PORT, 16'hFFFF);
    repeat (2) send_tick();
    drain();
    write_reg(pkat_pkg::CFG_BC_ENABLE, 16'd0);
    repeat (2) send_tick();
    drain();
  endtask

  task automatic test_probe_and_evict();
    write_reg(pkat_pkg::CFG_PERIOD, 16'd0);
    write_reg(pkat_pkg::CFG_MAX_KA, 16'd1);
    send_item(pkat_pkg::OP_WRITE, 4'd0, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
    send_item(pkat_pkg::OP_WRITE, 4'd15, 32'h0000_0001, 16'h0001, 8'h00);
    send_item(pkat_pkg::OP_WRITE, 4'd5, 32'h0000_0000, 16'h1234, 8'h00);
    send_item(pkat_pkg::OP_WRITE, 4'd6, 32'hC0A8_0001, 16'h0000, 8'h00);
    repeat (6) send_tick();
    drain();
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    int r;
    sent = 0;
    while (sent < 320) begin
      drain();
      r = $urandom_range(0, 99);
      write_reg(pkat_pkg::CFG_PERIOD, (r < 50) ? 16'($urandom_range(0, 3)) :
                                      (r < 85) ? 16'($urandom_range(4, 30)) :
                                                 16'($urandom_range(31, 300)));
      r = $urandom_range(0, 99);
      write_reg(pkat_pkg::CFG_MAX_KA, (r < 60) ? 16'($urandom_range(0, 3)) :
                                      (r < 80) ? 16'd255 : 16'($urandom_range(0, 255)));
      write_reg(pkat_pkg::CFG_BC_ENABLE, 16'($urandom_range(0, 1)));
      write_reg(pkat_pkg::CFG_BC_PORT, 16'($urandom_range(0, 65535)));
      no_gaps = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        if ($urandom_range(0, 99) < 30)
          send_item(pkat_pkg::OP_WRITE, 4'($urandom_range(0, 15)),
                    ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom(),
                    ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom()),
                    ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) :
                                                 8'($urandom()));
        else
          send_tick();
      end
      sent += burst;
    end
    drain();
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 99) < 15) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_events.size() == 0) begin
        $error("event word with nothing expected: kind %0d slot %0d", out_tuser,
               out_tdata[3:0]);
        fail_count++;
      end else begin
        want = due_events.pop_front();
        check_field("event_kind", 32'(want.kind), 32'(out_tuser));
        check_field("event_slot", 32'(want.slot), 32'(out_tdata[3:0]));
        check_field("event_ip", want.ip, out_tdata[35:4]);
        check_field("event_port", 32'(want.port), 32'(out_tdata[51:36]));
        check_field("last", 32'(want.last), 32'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_broadcast();
    test_probe_and_evict();
    test_random_traffic();
    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pkat_pkg.sv
rtl/peer_keepalive_aging_table.sv
tb/peer_keepalive_aging_table_tb.sv
